// File: sv/stz_pkg.sv
// ----------------------------------------------------------------------------
// stz_pkg: shared types and constants of the stereo thru-zero flanger
// Sample type, gain and phase constants, register indexes, the per-step
// control word and the sample saturation helper.
// ----------------------------------------------------------------------------
package stz_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned GAIN_W   = 23;
  localparam int unsigned DELAY_W  = 27;
  localparam int unsigned IDX_W    = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           cfg_idx_t;
  typedef logic [DELAY_W-1:0]         cfg_data_t;

  // Register indexes on the configuration channel
  localparam cfg_idx_t REG_PHASE_STEP    = 3'd0;
  localparam cfg_idx_t REG_SWEEP_DEPTH   = 3'd1;
  localparam cfg_idx_t REG_DELAY_OFFSET  = 3'd2;
  localparam cfg_idx_t REG_WET_GAIN      = 3'd3;
  localparam cfg_idx_t REG_DRY_GAIN      = 3'd4;
  localparam cfg_idx_t REG_FEEDBACK_GAIN = 3'd5;

  // Q2.22 phase constants
  localparam logic signed [24:0] PH_ONE = 25'sh0400000;
  localparam logic signed [24:0] PH_TWO = 25'sh0800000;
  // Unity in Q1.22, also the dry gain after reset
  localparam logic [GAIN_W-1:0]  GAIN_ONE = 23'h400000;

  // One strobe per processing step of an item
  typedef struct packed {
    logic accept;    // item taken: phase, pointer, input sample
    logic square;    // phase squared, feedback and dry products
    logic modulate;  // depth partial products, ring write
    logic address;   // delay, tap addresses, fraction
    logic read;      // ring reads
    logic interp;    // linear interpolation, feedback update
    logic wet;       // wet product
    logic finish;    // merge loads the result pair
  } step_ctrl_t;

  // Clip a 26 bit intermediate to the signed sample range
  function automatic sample_t sat_sample(input logic signed [25:0] x);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sh07FFFFF;
    lo = -26'sh0800000;
    if (x > hi) begin
      return sample_t'(hi);
    end else if (x < lo) begin
      return sample_t'(lo);
    end
    return sample_t'(x);
  endfunction

endpackage

// File: sv/stz_if.sv
// ----------------------------------------------------------------------------
// stz_if: channel interfaces of the stereo thru-zero flanger
// Sample pair in, sample pair out, and the register write channel, each
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface stz_in_if;
  logic             valid;
  logic             ready;
  stz_pkg::sample_t left_in;
  stz_pkg::sample_t right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface stz_out_if;
  logic             valid;
  logic             ready;
  stz_pkg::sample_t left_out;
  stz_pkg::sample_t right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface stz_cfg_if;
  logic                valid;
  logic                ready;
  stz_pkg::cfg_idx_t   index;
  stz_pkg::cfg_data_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/stereo_thru_zero_flanger.sv
// ----------------------------------------------------------------------------
// stereo_thru_zero_flanger: stereo thru-zero flanger, top level
// Two channel lanes share one sweep unit and feed one merge stage; a
// step sequencer walks each request through the lanes.
//
//   channel  dir  payload                     handshake
//   in_ch    in   left_in, right_in (s24)     valid / ready
//   out_ch   out  left_out, right_out (s24)   valid / ready
//   cfg_ch   in   index (3), data (27)        valid / ready, always ready
//
// From acceptance to a loaded result pair a request walks the step
// sequence: square, modulate and write, address, ring read, interpolate,
// wet product, merge. The next request is taken once the sequence
// returns to idle, so a new request is not taken before the last one is
// merged, while the previous pair may still wait in the output register;
// a merge is held only while that register is still full.
// Reset is synchronous; the rings need no clearing pass, a fill count
// marks entries never written and they read as zero.
// ----------------------------------------------------------------------------
module stereo_thru_zero_flanger #(
  parameter int unsigned DELAY_ADDR_BITS = 11   // ring depth 2**bits, 8 to 13
) (
  input  logic        clk,
  input  logic        rst_n,
  stz_in_if.sink      in_ch,
  stz_out_if.source   out_ch,
  stz_cfg_if.sink     cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MODULATE,
    ST_ADDRESS,
    ST_READ,
    ST_INTERP,
    ST_WET,
    ST_OUT
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  stz_pkg::step_ctrl_t  ctrl;
  logic                 load_ok;

  logic [22:0]          phase_step_r;
  logic [26:0]          sweep_depth_r;
  logic [26:0]          delay_offset_r;
  logic [22:0]          wet_gain_r;
  logic [22:0]          dry_gain_r;
  logic signed [22:0]   feedback_gain_r;

  logic [DELAY_ADDR_BITS-1:0] wr_addr;
  logic [DELAY_ADDR_BITS-1:0] rd_addr0;
  logic [DELAY_ADDR_BITS-1:0] rd_addr1;
  logic                       rd_ok0;
  logic                       rd_ok1;
  logic [15:0]                frac;
  logic signed [46:0]         left_dry;
  logic signed [46:0]         left_wet;
  logic signed [46:0]         right_dry;
  logic signed [46:0]         right_wet;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      sweep_depth_r   <= '0;
      delay_offset_r  <= '0;
      wet_gain_r      <= '0;
      dry_gain_r      <= stz_pkg::GAIN_ONE;
      feedback_gain_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        stz_pkg::REG_PHASE_STEP:    phase_step_r    <= cfg_ch.data[22:0];
        stz_pkg::REG_SWEEP_DEPTH:   sweep_depth_r   <= cfg_ch.data;
        stz_pkg::REG_DELAY_OFFSET:  delay_offset_r  <= cfg_ch.data;
        stz_pkg::REG_WET_GAIN:      wet_gain_r      <= cfg_ch.data[22:0];
        stz_pkg::REG_DRY_GAIN:      dry_gain_r      <= cfg_ch.data[22:0];
        stz_pkg::REG_FEEDBACK_GAIN: feedback_gain_r <= $signed(cfg_ch.data[22:0]);
        default: ;
      endcase
    end
  end

  // Step sequencer
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    ctrl          = '0;
    ctrl.accept   = in_ch.valid && (state_r == ST_IDLE);
    ctrl.square   = (state_r == ST_SQUARE);
    ctrl.modulate = (state_r == ST_MODULATE);
    ctrl.address  = (state_r == ST_ADDRESS);
    ctrl.read     = (state_r == ST_READ);
    ctrl.interp   = (state_r == ST_INTERP);
    ctrl.wet      = (state_r == ST_WET);
    ctrl.finish   = (state_r == ST_OUT) && load_ok;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_SQUARE;
      ST_SQUARE:   state_nxt = ST_MODULATE;
      ST_MODULATE: state_nxt = ST_ADDRESS;
      ST_ADDRESS:  state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_INTERP;
      ST_INTERP:   state_nxt = ST_WET;
      ST_WET:      state_nxt = ST_OUT;
      ST_OUT:      if (load_ok) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared sweep and addressing
  stz_sweep #(
    .ADDR_BITS (DELAY_ADDR_BITS)
  ) u_sweep (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .phase_step   (phase_step_r),
    .sweep_depth  (sweep_depth_r),
    .delay_offset (delay_offset_r),
    .wr_addr      (wr_addr),
    .rd_addr0     (rd_addr0),
    .rd_addr1     (rd_addr1),
    .rd_ok0       (rd_ok0),
    .rd_ok1       (rd_ok1),
    .frac         (frac)
  );

  // Channel lanes
  stz_lane #(
    .ADDR_BITS (DELAY_ADDR_BITS)
  ) u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sample_in (in_ch.left_in),
    .fb_gain   (feedback_gain_r),
    .dry_gain  (dry_gain_r),
    .wet_gain  (wet_gain_r),
    .wr_addr   (wr_addr),
    .rd_addr0  (rd_addr0),
    .rd_addr1  (rd_addr1),
    .rd_ok0    (rd_ok0),
    .rd_ok1    (rd_ok1),
    .frac      (frac),
    .dry_prod  (left_dry),
    .wet_prod  (left_wet)
  );

  stz_lane #(
    .ADDR_BITS (DELAY_ADDR_BITS)
  ) u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sample_in (in_ch.right_in),
    .fb_gain   (feedback_gain_r),
    .dry_gain  (dry_gain_r),
    .wet_gain  (wet_gain_r),
    .wr_addr   (wr_addr),
    .rd_addr0  (rd_addr0),
    .rd_addr1  (rd_addr1),
    .rd_ok0    (rd_ok0),
    .rd_ok1    (rd_ok1),
    .frac      (frac),
    .dry_prod  (right_dry),
    .wet_prod  (right_wet)
  );

  // Merge and output register
  stz_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctrl.finish),
    .load_ok   (load_ok),
    .left_dry  (left_dry),
    .left_wet  (left_wet),
    .right_dry (right_dry),
    .right_wet (right_wet),
    .out_ch    (out_ch)
  );

endmodule

// File: sv/stz_sweep.sv
// ----------------------------------------------------------------------------
// stz_sweep: shared sweep and ring addressing unit
// Advances the phase, shapes the delay as offset + depth * (1 - phase^2),
// and produces write pointer, two tap addresses, their written flags and
// the interpolation fraction for both lanes.
// ----------------------------------------------------------------------------
module stz_sweep #(
  parameter int unsigned ADDR_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stz_pkg::step_ctrl_t     ctrl,
  input  logic [22:0]             phase_step,
  input  logic [26:0]             sweep_depth,
  input  logic [26:0]             delay_offset,
  output logic [ADDR_BITS-1:0]    wr_addr,
  output logic [ADDR_BITS-1:0]    rd_addr0,
  output logic [ADDR_BITS-1:0]    rd_addr1,
  output logic                    rd_ok0,
  output logic                    rd_ok1,
  output logic [15:0]             frac
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;
  localparam int unsigned SUM_W = (ADDR_BITS > 12) ? ADDR_BITS : 12;

  logic signed [24:0]      phase_r;
  logic signed [24:0]      phase_sum;
  logic signed [24:0]      phase_nxt;
  logic [ADDR_BITS-1:0]    wp_r;
  logic [ADDR_BITS:0]      fill_r;
  logic signed [49:0]      sq_full;
  logic [44:0]             sq_r;
  logic [22:0]             shape;
  logic [38:0]             pp_lo_r;
  logic [33:0]             pp_hi_r;
  logic [49:0]             prod;
  logic [27:0]             delay;
  logic [SUM_W:0]          pos_sum;
  logic [ADDR_BITS-1:0]    p0;
  logic [ADDR_BITS-1:0]    p1;
  logic [ADDR_BITS-1:0]    dist0;
  logic [ADDR_BITS-1:0]    dist1;
  logic [ADDR_BITS-1:0]    p0_r;
  logic [ADDR_BITS-1:0]    p1_r;
  logic                    ok0_r;
  logic                    ok1_r;
  logic [15:0]             frac_r;

  // Phase advance with a single wrap from above +1 down by 2
  always_comb begin
    phase_sum = phase_r + $signed({2'b00, phase_step});
    phase_nxt = (phase_sum > stz_pkg::PH_ONE) ? phase_sum - stz_pkg::PH_TWO : phase_sum;
  end

  // Sweep shape and delay
  always_comb begin
    sq_full = phase_r * phase_r;
    shape   = stz_pkg::GAIN_ONE - sq_r[44:22];
    prod    = {pp_hi_r, 16'b0} + {11'b0, pp_lo_r};
    delay   = {1'b0, delay_offset} + prod[49:22];
  end

  // Tap addresses; an entry counts as written if it lies within the fill
  // window that starts at the write pointer
  always_comb begin
    pos_sum = (SUM_W+1)'(delay[27:16]) + (SUM_W+1)'(wp_r);
    p0      = pos_sum[ADDR_BITS-1:0];
    p1      = p0 + 1'b1;
    dist0   = p0 - wp_r;
    dist1   = p1 - wp_r;
  end

  // Sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      wp_r    <= '0;
      fill_r  <= '0;
    end else if (ctrl.accept) begin
      phase_r <= phase_nxt;
      wp_r    <= wp_r - 1'b1;
      if (fill_r != (ADDR_BITS+1)'(DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (ctrl.square) begin
      sq_r <= sq_full[44:0];
    end
    if (ctrl.modulate) begin
      pp_lo_r <= sweep_depth[15:0] * shape;
      pp_hi_r <= sweep_depth[26:16] * shape;
    end
    if (ctrl.address) begin
      p0_r   <= p0;
      p1_r   <= p1;
      ok0_r  <= {1'b0, dist0} < fill_r;
      ok1_r  <= {1'b0, dist1} < fill_r;
      frac_r <= delay[15:0];
    end
  end

  assign wr_addr  = wp_r;
  assign rd_addr0 = p0_r;
  assign rd_addr1 = p1_r;
  assign rd_ok0   = ok0_r;
  assign rd_ok1   = ok1_r;
  assign frac     = frac_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (ADDR_BITS+1)'(DEPTH))
    else $error("fill count beyond ring depth");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= stz_pkg::PH_ONE) && (phase_r > -stz_pkg::PH_ONE))
    else $error("sweep phase outside (-1, +1]");

  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept |=> (wp_r == ADDR_BITS'($past(wp_r) - 1'b1)) &&
                    ((fill_r == $past(fill_r) + 1'b1) ||
                     (fill_r == (ADDR_BITS+1)'(DEPTH))))
    else $error("write pointer or fill count did not advance with request");

endmodule

// File: sv/stz_lane.sv
// ----------------------------------------------------------------------------
// stz_lane: one channel of the flanger
// Holds the channel's delay ring and feedback value; writes input plus
// feedback, reads two taps, interpolates, and forms dry and wet products.
// ----------------------------------------------------------------------------
module stz_lane #(
  parameter int unsigned ADDR_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stz_pkg::step_ctrl_t   ctrl,
  input  stz_pkg::sample_t      sample_in,
  input  logic signed [22:0]    fb_gain,
  input  logic [22:0]           dry_gain,
  input  logic [22:0]           wet_gain,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [ADDR_BITS-1:0]  rd_addr0,
  input  logic [ADDR_BITS-1:0]  rd_addr1,
  input  logic                  rd_ok0,
  input  logic                  rd_ok1,
  input  logic [15:0]           frac,
  output logic signed [46:0]    dry_prod,
  output logic signed [46:0]    wet_prod
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  stz_pkg::sample_t    ring [DEPTH];
  stz_pkg::sample_t    in_r;
  stz_pkg::sample_t    fb_r;
  stz_pkg::sample_t    rd0_r;
  stz_pkg::sample_t    rd1_r;
  logic                ok0_r;
  logic                ok1_r;
  logic signed [46:0]  fbp_r;
  logic signed [46:0]  dry_r;
  logic signed [46:0]  wet_r;
  logic signed [25:0]  wr_sum;
  stz_pkg::sample_t    wr_val;
  stz_pkg::sample_t    r0;
  stz_pkg::sample_t    r1;
  logic signed [24:0]  diff;
  logic signed [41:0]  ip;
  logic signed [25:0]  d_full;

  // Ring write value: input plus floored feedback term, clipped
  always_comb begin
    wr_sum = {{2{in_r[23]}}, in_r} + {fbp_r[46], fbp_r[46:22]};
    wr_val = stz_pkg::sat_sample(wr_sum);
  end

  // Linear interpolation; entries never written read as zero
  always_comb begin
    r0     = ok0_r ? rd0_r : '0;
    r1     = ok1_r ? rd1_r : '0;
    diff   = {r1[23], r1} - {r0[23], r0};
    ip     = diff * $signed({1'b0, frac});
    d_full = {{2{r0[23]}}, r0} + ip[41:16];
  end

  // Delay ring
  always_ff @(posedge clk) begin
    if (ctrl.modulate) begin
      ring[wr_addr] <= wr_val;
    end
    if (ctrl.read) begin
      rd0_r <= ring[rd_addr0];
      rd1_r <= ring[rd_addr1];
    end
  end

  // Feedback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else if (ctrl.interp) begin
      fb_r <= d_full[23:0];
    end
  end

  // Sample, product and tap flag registers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      in_r <= sample_in;
    end
    if (ctrl.square) begin
      fbp_r <= fb_gain * fb_r;
      dry_r <= in_r * $signed({1'b0, dry_gain});
    end
    if (ctrl.read) begin
      ok0_r <= rd_ok0;
      ok1_r <= rd_ok1;
    end
    if (ctrl.wet) begin
      wet_r <= fb_r * $signed({1'b0, wet_gain});
    end
  end

  assign dry_prod = dry_r;
  assign wet_prod = wet_r;

endmodule

// File: sv/stz_merge.sv
// ----------------------------------------------------------------------------
// stz_merge: output merge stage
// Combines the dry and wet products of both lanes into a clipped stereo
// pair and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module stz_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  output logic               load_ok,
  input  logic signed [46:0] left_dry,
  input  logic signed [46:0] left_wet,
  input  logic signed [46:0] right_dry,
  input  logic signed [46:0] right_wet,
  stz_out_if.source          out_ch
);

  logic               valid_r;
  stz_pkg::sample_t   left_r;
  stz_pkg::sample_t   right_r;
  logic signed [47:0] left_diff;
  logic signed [47:0] right_diff;

  // dry minus wet, floored by 22 bits
  always_comb begin
    left_diff  = {left_dry[46], left_dry} - {left_wet[46], left_wet};
    right_diff = {right_dry[46], right_dry} - {right_wet[46], right_wet};
  end

  assign load_ok = !valid_r || out_ch.ready;

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Output pair
  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= stz_pkg::sat_sample(left_diff[47:22]);
      right_r <= stz_pkg::sat_sample(right_diff[47:22]);
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.left_out  = left_r;
  assign out_ch.right_out = right_r;

endmodule
